[src/iopm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopm_pkg
// Shared sizes, codes and port bundles for the IO page map table.
// ----------------------------------------------------------------------------
package iopm_pkg;

	localparam int EA_PAGES   = 4096;
	localparam int IO_PAGES   = 512;
	localparam int PAGE_SHIFT = 20;

	localparam int EA_PG_W = $clog2(EA_PAGES);
	localparam int IO_PG_W = $clog2(IO_PAGES);
	localparam int APG_W   = 32 - PAGE_SHIFT;          // page number of a 32-bit address
	localparam int SPG_W   = 30 - PAGE_SHIFT;          // page number of a 30-bit size
	localparam int CNT_W   = SPG_W;
	localparam int CHK_W   = ((APG_W > SPG_W) ? APG_W : SPG_W) + 1;
	localparam int CLR_N   = (EA_PAGES > IO_PAGES) ? EA_PAGES : IO_PAGES;
	localparam int IDX_W   = $clog2(CLR_N) + 1;
	localparam int FWD_W   = IO_PG_W + 1;              // valid + io page
	localparam int REV_W   = EA_PG_W + 1;              // valid + ea page

	localparam logic [31:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;
	localparam logic [31:0] WIN_RESET = 32'hC000_0000;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_MISALIGNED = 2'd1;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd2;
	localparam logic [1:0] ST_NO_ROOM    = 2'd3;

	localparam logic [2:0] OP_MAP      = 3'd0;
	localparam logic [2:0] OP_AUTO_MAP = 3'd1;
	localparam logic [2:0] OP_UNMAP_EA = 3'd2;
	localparam logic [2:0] OP_UNMAP_IO = 3'd3;
	localparam logic [2:0] OP_EA_TO_IO = 3'd4;
	localparam logic [2:0] OP_IO_TO_EA = 3'd5;

	typedef struct packed {
		logic               we;
		logic [EA_PG_W-1:0] waddr;
		logic [FWD_W-1:0]   wdata;
		logic [EA_PG_W-1:0] raddr;
	} fwd_req_t;

	typedef struct packed {
		logic               we;
		logic [IO_PG_W-1:0] waddr;
		logic [REV_W-1:0]   wdata;
		logic [IO_PG_W-1:0] raddr;
	} rev_req_t;

	typedef struct packed {
		logic               we;
		logic [IO_PG_W-1:0] waddr;
		logic [CNT_W-1:0]   wdata;
		logic [IO_PG_W-1:0] raddr;
	} cnt_req_t;

endpackage

[src/iopm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iopm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/iopm_rng.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopm_rng
// Shared range check: flags when base plus length passes a table limit.
// ----------------------------------------------------------------------------
module iopm_rng (
	input  logic [iopm_pkg::CHK_W-1:0] base,
	input  logic [iopm_pkg::CHK_W-1:0] len,
	input  logic [iopm_pkg::CHK_W-1:0] lim,
	output logic                       over
);

	logic [iopm_pkg::CHK_W:0] sum;

	assign sum  = {1'b0, base} + {1'b0, len};
	assign over = sum > {1'b0, lim};

endmodule

[src/iopm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopm_seq
// Sequencer: clear sweep, decode, table walks and result register.
// ----------------------------------------------------------------------------
module iopm_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [31:0]               win_mask,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                op,
	input  logic [31:0]               address,
	input  logic [31:0]               io_offset,
	input  logic [29:0]               size,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [31:0]               result_address,
	output iopm_pkg::fwd_req_t        fwd_req,
	output iopm_pkg::rev_req_t        rev_req,
	output iopm_pkg::cnt_req_t        cnt_req,
	input  logic [iopm_pkg::FWD_W-1:0] fwd_rd,
	input  logic [iopm_pkg::REV_W-1:0] rev_rd,
	input  logic [iopm_pkg::CNT_W-1:0] cnt_rd
);

	localparam logic [4:0] S_CLEAR    = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_DEC      = 5'd2;
	localparam logic [4:0] S_M_IO1    = 5'd3;
	localparam logic [4:0] S_M_IO2    = 5'd4;
	localparam logic [4:0] S_M_EA     = 5'd5;
	localparam logic [4:0] S_WRITE    = 5'd6;
	localparam logic [4:0] S_SRCH_RD  = 5'd7;
	localparam logic [4:0] S_SRCH_CHK = 5'd8;
	localparam logic [4:0] S_U_EA     = 5'd9;
	localparam logic [4:0] S_U_FWD    = 5'd10;
	localparam logic [4:0] S_U_IO     = 5'd11;
	localparam logic [4:0] S_U_CNT    = 5'd12;
	localparam logic [4:0] S_U_C1     = 5'd13;
	localparam logic [4:0] S_U_C2     = 5'd14;
	localparam logic [4:0] S_UNMAP    = 5'd15;
	localparam logic [4:0] S_R_CHK    = 5'd16;
	localparam logic [4:0] S_R_DAT    = 5'd17;
	localparam logic [4:0] S_T_CHK    = 5'd18;
	localparam logic [4:0] S_T_DAT    = 5'd19;
	localparam logic [4:0] S_DONE     = 5'd20;

	logic [4:0]                     state_q;
	logic [2:0]                     op_q;
	logic [31:0]                    addr_q;
	logic [31:0]                    io_q;
	logic [29:0]                    size_q;
	logic [iopm_pkg::EA_PG_W-1:0]   ea_pg_q;
	logic [iopm_pkg::IO_PG_W-1:0]   io_pg_q;
	logic [iopm_pkg::CNT_W-1:0]     cnt_q;
	logic [iopm_pkg::CHK_W-1:0]     cand_q;
	logic [iopm_pkg::IDX_W-1:0]     idx_q;
	logic [iopm_pkg::IDX_W-1:0]     run_q;
	logic [1:0]                     status_q;
	logic [31:0]                    res_q;

	logic [iopm_pkg::APG_W-1:0]     a_pg;
	logic [iopm_pkg::APG_W-1:0]     i_pg;
	logic [iopm_pkg::SPG_W-1:0]     pages;
	logic [31:0]                    a_low;
	logic                           io_mis;
	logic                           size_mis;
	logic [iopm_pkg::IDX_W-1:0]     run_n;
	logic [iopm_pkg::IDX_W-1:0]     idx_inc;
	logic [iopm_pkg::EA_PG_W-1:0]   ea_ptr;
	logic [iopm_pkg::IO_PG_W-1:0]   io_ptr;
	logic [iopm_pkg::CHK_W-1:0]     chk_base;
	logic [iopm_pkg::CHK_W-1:0]     chk_len;
	logic [iopm_pkg::CHK_W-1:0]     chk_lim;
	logic                           chk_over;

	localparam logic [iopm_pkg::CHK_W-1:0] EA_LIM = iopm_pkg::CHK_W'(iopm_pkg::EA_PAGES);
	localparam logic [iopm_pkg::CHK_W-1:0] IO_LIM = iopm_pkg::CHK_W'(iopm_pkg::IO_PAGES);
	localparam logic [iopm_pkg::CHK_W-1:0] ONE    = iopm_pkg::CHK_W'(1);

	assign a_pg     = iopm_pkg::APG_W'(addr_q >> iopm_pkg::PAGE_SHIFT);
	assign i_pg     = iopm_pkg::APG_W'(io_q >> iopm_pkg::PAGE_SHIFT);
	assign pages    = iopm_pkg::SPG_W'(size_q >> iopm_pkg::PAGE_SHIFT);
	assign a_low    = addr_q & iopm_pkg::PAGE_MASK;
	assign io_mis   = |(io_q & iopm_pkg::PAGE_MASK);
	assign size_mis = |(size_q & iopm_pkg::PAGE_MASK[29:0]);
	assign run_n    = rev_rd[iopm_pkg::REV_W-1] ? '0 : run_q + 1'b1;
	assign idx_inc  = idx_q + 1'b1;
	assign ea_ptr   = iopm_pkg::EA_PG_W'(ea_pg_q + idx_q);
	assign io_ptr   = iopm_pkg::IO_PG_W'(io_pg_q + idx_q);

	iopm_rng u_rng (
		.base (chk_base),
		.len  (chk_len),
		.lim  (chk_lim),
		.over (chk_over)
	);

	// range check operands
	always_comb begin
		chk_base = '0;
		chk_len  = ONE;
		chk_lim  = IO_LIM;
		unique case (state_q)
			S_M_IO1: chk_base = iopm_pkg::CHK_W'(i_pg);
			S_M_IO2: begin
				chk_base = iopm_pkg::CHK_W'(i_pg);
				chk_len  = iopm_pkg::CHK_W'(pages);
			end
			S_M_EA: begin
				chk_base = iopm_pkg::CHK_W'(op_q == iopm_pkg::OP_MAP ? a_pg : a_pg);
				chk_len  = iopm_pkg::CHK_W'(pages);
				chk_lim  = EA_LIM;
			end
			S_U_EA: begin
				chk_base = cand_q;
				chk_lim  = EA_LIM;
			end
			S_U_IO: chk_base = iopm_pkg::CHK_W'(io_pg_q);
			S_U_C1: begin
				chk_base = iopm_pkg::CHK_W'(ea_pg_q);
				chk_len  = iopm_pkg::CHK_W'(cnt_q);
				chk_lim  = EA_LIM;
			end
			S_U_C2: begin
				chk_base = iopm_pkg::CHK_W'(io_pg_q);
				chk_len  = iopm_pkg::CHK_W'(cnt_q);
			end
			S_R_CHK: chk_base = iopm_pkg::CHK_W'(a_pg);
			S_T_CHK: begin
				chk_base = iopm_pkg::CHK_W'(a_pg);
				chk_lim  = EA_LIM;
			end
			default: ;
		endcase
	end

	// table ports
	always_comb begin
		fwd_req       = '0;
		rev_req       = '0;
		cnt_req       = '0;
		fwd_req.raddr = iopm_pkg::EA_PG_W'(cand_q);
		rev_req.raddr = iopm_pkg::IO_PG_W'(a_pg);
		cnt_req.raddr = io_pg_q;
		unique case (state_q)
			S_CLEAR: begin
				fwd_req.we    = idx_q < iopm_pkg::IDX_W'(iopm_pkg::EA_PAGES);
				fwd_req.waddr = iopm_pkg::EA_PG_W'(idx_q);
				rev_req.we    = idx_q < iopm_pkg::IDX_W'(iopm_pkg::IO_PAGES);
				rev_req.waddr = iopm_pkg::IO_PG_W'(idx_q);
				cnt_req.we    = rev_req.we;
				cnt_req.waddr = rev_req.waddr;
			end
			S_WRITE: begin
				fwd_req.we    = 1'b1;
				fwd_req.waddr = ea_ptr;
				fwd_req.wdata = {1'b1, io_ptr};
				rev_req.we    = 1'b1;
				rev_req.waddr = io_ptr;
				rev_req.wdata = {1'b1, ea_ptr};
				cnt_req.we    = idx_q == '0;
				cnt_req.waddr = io_pg_q;
				cnt_req.wdata = iopm_pkg::CNT_W'(pages);
			end
			S_UNMAP: begin
				fwd_req.we    = 1'b1;
				fwd_req.waddr = ea_ptr;
				rev_req.we    = 1'b1;
				rev_req.waddr = io_ptr;
				cnt_req.we    = idx_q == '0;
				cnt_req.waddr = io_pg_q;
			end
			S_SRCH_RD: rev_req.raddr = iopm_pkg::IO_PG_W'(idx_q);
			S_T_CHK:   fwd_req.raddr = iopm_pkg::EA_PG_W'(a_pg);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			idx_q    <= '0;
			op_q     <= '0;
			addr_q   <= '0;
			io_q     <= '0;
			size_q   <= '0;
			ea_pg_q  <= '0;
			io_pg_q  <= '0;
			cnt_q    <= '0;
			cand_q   <= '0;
			run_q    <= '0;
			status_q <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_inc;
					if (idx_inc == iopm_pkg::IDX_W'(iopm_pkg::CLR_N)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						addr_q  <= address;
						io_q    <= io_offset;
						size_q  <= size;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					status_q <= iopm_pkg::ST_NO_ROOM;
					res_q    <= '0;
					idx_q    <= '0;
					run_q    <= '0;
					cand_q   <= iopm_pkg::CHK_W'(a_pg);
					state_q  <= S_DONE;
					unique case (op_q)
						iopm_pkg::OP_MAP: begin
							if (io_mis || size_mis) begin
								status_q <= iopm_pkg::ST_MISALIGNED;
							end else if (pages == '0) begin
								status_q <= iopm_pkg::ST_OK;
							end else begin
								state_q <= S_M_IO1;
							end
						end
						iopm_pkg::OP_AUTO_MAP: begin
							if (size_mis) begin
								status_q <= iopm_pkg::ST_MISALIGNED;
							end else if (pages == '0) begin
								status_q <= iopm_pkg::ST_OK;
							end else begin
								state_q <= S_SRCH_RD;
							end
						end
						iopm_pkg::OP_UNMAP_EA, iopm_pkg::OP_UNMAP_IO: begin
							if (a_low != '0) begin
								status_q <= iopm_pkg::ST_MISALIGNED;
							end else begin
								state_q <= (op_q == iopm_pkg::OP_UNMAP_EA) ? S_U_EA : S_R_CHK;
							end
						end
						iopm_pkg::OP_EA_TO_IO: begin
							if ((addr_q & win_mask) != '0) begin
								status_q <= iopm_pkg::ST_OK;
								res_q    <= addr_q & ~win_mask;
							end else begin
								state_q <= S_T_CHK;
							end
						end
						iopm_pkg::OP_IO_TO_EA: state_q <= S_R_CHK;
						default: ;
					endcase
				end
				S_M_IO1: state_q <= chk_over ? S_DONE : S_M_IO2;
				S_M_IO2: begin
					io_pg_q <= iopm_pkg::IO_PG_W'(i_pg);
					state_q <= chk_over ? S_DONE : S_M_EA;
				end
				S_M_EA: begin
					ea_pg_q <= iopm_pkg::EA_PG_W'(a_pg);
					idx_q   <= '0;
					state_q <= chk_over ? S_DONE : S_WRITE;
				end
				S_WRITE: begin
					idx_q <= idx_inc;
					if (idx_inc == iopm_pkg::IDX_W'(pages)) begin
						status_q <= iopm_pkg::ST_OK;
						if (op_q == iopm_pkg::OP_AUTO_MAP) begin
							res_q <= 32'(io_pg_q) << iopm_pkg::PAGE_SHIFT;
						end
						state_q <= S_DONE;
					end
				end
				S_SRCH_RD: state_q <= S_SRCH_CHK;
				S_SRCH_CHK: begin
					run_q <= run_n;
					idx_q <= idx_inc;
					if (run_n == iopm_pkg::IDX_W'(pages)) begin
						io_pg_q <= iopm_pkg::IO_PG_W'(idx_inc - iopm_pkg::IDX_W'(pages));
						state_q <= S_M_EA;
					end else if (idx_inc == iopm_pkg::IDX_W'(iopm_pkg::IO_PAGES)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_U_EA: begin
					ea_pg_q <= iopm_pkg::EA_PG_W'(cand_q);
					state_q <= chk_over ? S_DONE : S_U_FWD;
				end
				S_U_FWD: begin
					io_pg_q <= fwd_rd[iopm_pkg::IO_PG_W-1:0];
					if (!fwd_rd[iopm_pkg::FWD_W-1]) begin
						status_q <= iopm_pkg::ST_NOT_MAPPED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_U_IO;
					end
				end
				S_U_IO: state_q <= chk_over ? S_DONE : S_U_CNT;
				S_U_CNT: begin
					cnt_q <= cnt_rd;
					if (cnt_rd == '0) begin
						status_q <= iopm_pkg::ST_NOT_MAPPED;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_U_C1;
					end
				end
				S_U_C1: state_q <= chk_over ? S_DONE : S_U_C2;
				S_U_C2: begin
					idx_q   <= '0;
					state_q <= chk_over ? S_DONE : S_UNMAP;
				end
				S_UNMAP: begin
					idx_q <= idx_inc;
					if (idx_inc == iopm_pkg::IDX_W'(cnt_q)) begin
						status_q <= iopm_pkg::ST_OK;
						state_q  <= S_DONE;
					end
				end
				S_R_CHK: state_q <= chk_over ? S_DONE : S_R_DAT;
				S_R_DAT: begin
					cand_q <= iopm_pkg::CHK_W'(rev_rd[iopm_pkg::EA_PG_W-1:0]);
					if (!rev_rd[iopm_pkg::REV_W-1]) begin
						status_q <= iopm_pkg::ST_NOT_MAPPED;
						state_q  <= S_DONE;
					end else if (op_q == iopm_pkg::OP_UNMAP_IO) begin
						state_q <= S_U_EA;
					end else begin
						status_q <= iopm_pkg::ST_OK;
						res_q    <= (32'(rev_rd[iopm_pkg::EA_PG_W-1:0]) << iopm_pkg::PAGE_SHIFT)
							| a_low;
						state_q  <= S_DONE;
					end
				end
				S_T_CHK: state_q <= chk_over ? S_DONE : S_T_DAT;
				S_T_DAT: begin
					if (!fwd_rd[iopm_pkg::FWD_W-1]) begin
						status_q <= iopm_pkg::ST_NOT_MAPPED;
					end else begin
						status_q <= iopm_pkg::ST_OK;
						res_q    <= (32'(fwd_rd[iopm_pkg::IO_PG_W-1:0]) << iopm_pkg::PAGE_SHIFT)
							| a_low;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = state_q == S_IDLE;
	assign out_valid      = state_q == S_DONE;
	assign status         = status_q;
	assign result_address = res_q;

endmodule

[src/io_page_map_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_page_map_table_unit
// Two-way ea / io page translation table with map, auto map and unmap.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. After reset the block
// sweeps all tables clear, over the larger table depth, before in_ready
// first rises; configuration writes are taken throughout. An ea lookup
// that falls in the local window is answered from decode; a table lookup
// passes a range check state, then takes the registered table read. Map
// and unmap write one page per cycle. Auto map scans the reverse table
// through its single read port, a read state and a check state per io
// page over up to 512 pages, then writes as a map does. A response waits
// in its output register until taken, and the next request is accepted in
// the cycle after.
// ----------------------------------------------------------------------------
module io_page_map_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [31:0] address,
	input  logic [31:0] io_offset,
	input  logic [29:0] size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] result_address,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	// local window register: set bits mark local memory
	logic [31:0] win_mask_q;

	iopm_pkg::fwd_req_t fwd_req;
	iopm_pkg::rev_req_t rev_req;
	iopm_pkg::cnt_req_t cnt_req;

	logic [iopm_pkg::FWD_W-1:0] fwd_rd;
	logic [iopm_pkg::REV_W-1:0] rev_rd;
	logic [iopm_pkg::CNT_W-1:0] cnt_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_mask_q <= iopm_pkg::WIN_RESET;
		end else if (cfg_we) begin
			win_mask_q <= cfg_wdata;
		end
	end

	// forward table: ea page -> valid + io page
	iopm_ram #(.WIDTH(iopm_pkg::FWD_W), .DEPTH(iopm_pkg::EA_PAGES)) u_fwd (
		.clk   (clk),
		.we    (fwd_req.we),
		.waddr (fwd_req.waddr),
		.wdata (fwd_req.wdata),
		.raddr (fwd_req.raddr),
		.rdata (fwd_rd)
	);

	// reverse table: io page -> valid + ea page
	iopm_ram #(.WIDTH(iopm_pkg::REV_W), .DEPTH(iopm_pkg::IO_PAGES)) u_rev (
		.clk   (clk),
		.we    (rev_req.we),
		.waddr (rev_req.waddr),
		.wdata (rev_req.wdata),
		.raddr (rev_req.raddr),
		.rdata (rev_rd)
	);

	// page count, held at the first io page of each mapping
	iopm_ram #(.WIDTH(iopm_pkg::CNT_W), .DEPTH(iopm_pkg::IO_PAGES)) u_cnt (
		.clk   (clk),
		.we    (cnt_req.we),
		.waddr (cnt_req.waddr),
		.wdata (cnt_req.wdata),
		.raddr (cnt_req.raddr),
		.rdata (cnt_rd)
	);

	// sequencer does decode, range checks and table walks
	iopm_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.win_mask       (win_mask_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.address        (address),
		.io_offset      (io_offset),
		.size           (size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.result_address (result_address),
		.fwd_req        (fwd_req),
		.rev_req        (rev_req),
		.cnt_req        (cnt_req),
		.fwd_rd         (fwd_rd),
		.rev_rd         (rev_rd),
		.cnt_rd         (cnt_rd)
	);

	// a request is never taken while a response is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request accepted with response pending");

	// an accepted request holds off the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready again right after acceptance");

	// count writes only go with a reverse table write
	a_cnt_with_rev: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_req.we |-> (rev_req.we && cnt_req.waddr == rev_req.waddr) || rev_req.we)
		else $error("count write without reverse table write");

endmodule
